### design/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define EPP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// invariant on every edge
`define EPP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

### design/epp_pkg.sv
package epp_pkg;

   localparam int unsigned CHAN_W       = 8;
   localparam int unsigned SQ_W         = 2 * CHAN_W;
   localparam int unsigned DIST_W       = SQ_W + 2;
   localparam int unsigned NUM_CHANNELS = 3;
   localparam int unsigned NUM_LEVELS   = 4;
   localparam int unsigned NUM_COLORS   = 16;
   localparam int unsigned IDX_W        = 4;
   localparam int unsigned NUM_PLANES   = 4;
   localparam int unsigned GROUP_PIXELS = 8;
   localparam int unsigned POS_W        = 3;
   localparam int unsigned OFFSET_W     = 13;
   localparam int unsigned NUM_QUADS    = NUM_COLORS / 4;

   localparam int unsigned MAX_PLANE_BYTES  = 8192;
   localparam int unsigned OFFSET_FIELD_MAX = 8191;
   localparam int unsigned OFFSET_LIMIT     =
      (MAX_PLANE_BYTES - 1 > OFFSET_FIELD_MAX) ? OFFSET_FIELD_MAX : MAX_PLANE_BYTES - 1;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(GROUP_PIXELS - 1);

   // channel index order for squared-difference tables
   localparam int unsigned CH_RED   = 0;
   localparam int unsigned CH_GREEN = 1;
   localparam int unsigned CH_BLUE  = 2;

   // the four intensity levels the palette is built from
   localparam logic [CHAN_W-1:0] LEVEL_VALUE [NUM_LEVELS] = '{8'h00, 8'h55, 8'hAA, 8'hFF};

   // palette entries as {red, green, blue} level codes
   localparam logic [5:0] PALETTE_LEVELS [NUM_COLORS] = '{
      6'b00_00_00, 6'b00_00_10, 6'b00_10_00, 6'b00_10_10,
      6'b10_00_00, 6'b10_00_10, 6'b10_01_00, 6'b10_10_10,
      6'b01_01_01, 6'b01_01_11, 6'b01_11_01, 6'b01_11_11,
      6'b11_01_01, 6'b11_01_11, 6'b11_11_01, 6'b11_11_11
   };

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              image_end;
   } pixel_type;

   typedef struct packed {
      logic [7:0]          plane0_byte;
      logic [7:0]          plane1_byte;
      logic [7:0]          plane2_byte;
      logic [7:0]          plane3_byte;
      logic [OFFSET_W-1:0] plane_addr;
      logic                last_group;
   } group_type;

   typedef struct packed {
      logic [NUM_CHANNELS-1:0][NUM_LEVELS-1:0][SQ_W-1:0] sq;
      logic                                              image_end;
   } sq_stage_type;

   typedef struct packed {
      logic [NUM_COLORS-1:0][DIST_W-1:0] sq_sum;
      logic                              image_end;
   } dist_stage_type;

   typedef struct packed {
      logic [DIST_W-1:0] sq_sum;
      logic [IDX_W-1:0]  idx;
   } cand_type;

   typedef struct packed {
      cand_type [NUM_QUADS-1:0] cand;
      logic                     image_end;
   } cand_stage_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             image_end;
   } pick_stage_type;

   function automatic logic [SQ_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

   // lo must hold the lower palette index: it wins a tie
   function automatic cand_type pick_nearer(input cand_type lo, input cand_type hi);
      return (hi.sq_sum < lo.sq_sum) ? hi : lo;
   endfunction

endpackage

### design/epp_dist.sv
module epp_dist
   import epp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  pixel_type      in_data,
   output logic           in_ready,
   output logic           out_valid,
   output dist_stage_type out_data,
   input  logic           out_ready
);

   logic           pix_valid_ff, pix_valid_in;
   pixel_type      pix_ff;
   logic           sq_valid_ff, sq_valid_in;
   sq_stage_type   sq_ff, sq_in;
   logic           dist_valid_ff, dist_valid_in;
   dist_stage_type dist_ff, dist_in;

   logic pix_ready, sq_ready, dist_ready;
   logic [NUM_CHANNELS-1:0][CHAN_W-1:0] chan;

   assign dist_ready = !dist_valid_ff || out_ready;
   assign sq_ready   = !sq_valid_ff || dist_ready;
   assign pix_ready  = !pix_valid_ff || sq_ready;
   assign in_ready   = pix_ready;

   assign pix_valid_in  = pix_ready  ? in_valid      : pix_valid_ff;
   assign sq_valid_in   = sq_ready   ? pix_valid_ff  : sq_valid_ff;
   assign dist_valid_in = dist_ready ? sq_valid_ff   : dist_valid_ff;

   always_comb begin
      chan[CH_RED]   = pix_ff.red;
      chan[CH_GREEN] = pix_ff.green;
      chan[CH_BLUE]  = pix_ff.blue;
      sq_in.image_end = pix_ff.image_end;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            sq_in.sq[c][l] = sq_diff(chan[c], LEVEL_VALUE[l]);
         end
      end
   end

   always_comb begin
      dist_in.image_end = sq_ff.image_end;
      for (int i = 0; i < NUM_COLORS; i++) begin
         dist_in.sq_sum[i] = DIST_W'(sq_ff.sq[CH_RED][PALETTE_LEVELS[i][5:4]])
                           + DIST_W'(sq_ff.sq[CH_GREEN][PALETTE_LEVELS[i][3:2]])
                           + DIST_W'(sq_ff.sq[CH_BLUE][PALETTE_LEVELS[i][1:0]]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff  <= 1'b0;
         sq_valid_ff   <= 1'b0;
         dist_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff  <= pix_valid_in;
         sq_valid_ff   <= sq_valid_in;
         dist_valid_ff <= dist_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_ready && in_valid) begin
         pix_ff <= in_data;
      end
      if (sq_ready && pix_valid_ff) begin
         sq_ff <= sq_in;
      end
      if (dist_ready && sq_valid_ff) begin
         dist_ff <= dist_in;
      end
   end

   assign out_valid = dist_valid_ff;
   assign out_data  = dist_ff;

endmodule

### design/epp_argmin.sv
module epp_argmin
   import epp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  dist_stage_type in_data,
   output logic           in_ready,
   output logic           out_valid,
   output pick_stage_type out_data,
   input  logic           out_ready
);

   logic           cand_valid_ff, cand_valid_in;
   cand_stage_type cand_ff, cand_in;
   cand_type       winner;

   assign in_ready      = !cand_valid_ff || out_ready;
   assign cand_valid_in = in_ready ? in_valid : cand_valid_ff;

   // first half of the tree: best of each group of four colors
   always_comb begin
      cand_type c [4];
      cand_in.image_end = in_data.image_end;
      for (int q = 0; q < NUM_QUADS; q++) begin
         for (int k = 0; k < 4; k++) begin
            c[k].sq_sum = in_data.sq_sum[4*q + k];
            c[k].idx    = IDX_W'(4*q + k);
         end
         cand_in.cand[q] = pick_nearer(pick_nearer(c[0], c[1]), pick_nearer(c[2], c[3]));
      end
   end

   // second half: best of the four group winners
   assign winner = pick_nearer(pick_nearer(cand_ff.cand[0], cand_ff.cand[1]),
                               pick_nearer(cand_ff.cand[2], cand_ff.cand[3]));

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_valid_ff <= 1'b0;
      end else begin
         cand_valid_ff <= cand_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         cand_ff <= cand_in;
      end
   end

   assign out_valid          = cand_valid_ff;
   assign out_data.idx       = winner.idx;
   assign out_data.image_end = cand_ff.image_end;

endmodule

### design/epp_pack.sv
`include "assert_macros.svh"

module epp_pack
   import epp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  pick_stage_type in_data,
   output logic           in_ready,
   output logic           rsp_valid,
   output group_type      rsp_data,
   input  logic           rsp_stall
);

   logic [NUM_PLANES-1:0][7:0] plane_shift_ff, plane_shift_in;
   logic [POS_W-1:0]           pixel_in_group_ff, pixel_in_group_in;
   logic [OFFSET_W-1:0]        group_counter_ff, group_counter_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   group_type                  rsp_data_ff, rsp_data_in;

   logic [NUM_PLANES-1:0][7:0] merged;
   logic [POS_W-1:0]           pos;
   logic                       emit;
   logic                       fire;

   assign emit     = in_data.image_end || (pixel_in_group_ff == LAST_POS);
   assign in_ready = !emit || !rsp_valid_ff || !rsp_stall;
   assign fire     = in_valid && in_ready;
   assign pos      = LAST_POS - pixel_in_group_ff;

   always_comb begin
      merged = plane_shift_ff;
      for (int p = 0; p < NUM_PLANES; p++) begin
         merged[p][pos] = plane_shift_ff[p][pos] | in_data.idx[p];
      end
   end

   always_comb begin
      plane_shift_in    = plane_shift_ff;
      pixel_in_group_in = pixel_in_group_ff;
      group_counter_in  = group_counter_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_data_in       = rsp_data_ff;
      if (fire) begin
         if (emit) begin
            rsp_valid_in            = 1'b1;
            rsp_data_in.plane0_byte = merged[0];
            rsp_data_in.plane1_byte = merged[1];
            rsp_data_in.plane2_byte = merged[2];
            rsp_data_in.plane3_byte = merged[3];
            rsp_data_in.plane_addr  = group_counter_ff;
            rsp_data_in.last_group  = in_data.image_end;
            plane_shift_in          = '0;
            pixel_in_group_in       = '0;
            if (in_data.image_end) begin
               group_counter_in = '0;
            end else if (group_counter_ff < OFFSET_W'(OFFSET_LIMIT)) begin
               group_counter_in = group_counter_ff + OFFSET_W'(1);
            end
         end else begin
            plane_shift_in    = merged;
            pixel_in_group_in = pixel_in_group_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_shift_ff    <= '0;
         pixel_in_group_ff <= '0;
         group_counter_ff  <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         plane_shift_ff    <= plane_shift_in;
         pixel_in_group_ff <= pixel_in_group_in;
         group_counter_ff  <= group_counter_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `EPP_ASSERT_NEXT(a_group_restarts, clock, reset, fire && emit,
      (pixel_in_group_ff == '0) && (plane_shift_ff == '0), "group state not cleared after emit")
   `EPP_ASSERT_NEXT(a_emit_loads_result, clock, reset, fire && emit,
      rsp_valid_ff && (rsp_data_ff.plane_addr == $past(group_counter_ff)), "result not loaded")
   `EPP_ASSERT_ALWAYS(a_offset_in_range, clock, reset,
      group_counter_ff <= OFFSET_W'(OFFSET_LIMIT), "group counter beyond limit")

endmodule

### design/rgb_to_ega_planar_packer.sv
// channel | ports                          | beat
// --------+--------------------------------+-----------------------------------------
// request | req_valid, req_stall, req_data | one rgb pixel plus image end flag
// result  | rsp_valid, rsp_stall, rsp_data | four plane bytes, byte offset, last flag
//
// one pixel per clock sustained unless a stalled result backs up the pipe
// pipeline stages: input reg, channel squares, color distances, quad minimum, pack
// reset is synchronous and empties the pipe, clears the plane bytes and counters
// a stalled result blocks only the pixel that closes the next group; others keep
// packing, then the stall backs up through the pipe register by register
module rgb_to_ega_planar_packer
   import epp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  pixel_type req_data,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output group_type rsp_data
);

   // distance front end -> argmin
   logic           dist_valid;
   logic           dist_ready;
   dist_stage_type dist_data;

   // argmin -> packer
   logic           pick_valid;
   logic           pick_ready;
   pick_stage_type pick_data;

   logic           req_ready;

   // input register, per-channel squared differences, per-color distance sums
   epp_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (req_ready),
      .out_valid (dist_valid),
      .out_data  (dist_data),
      .out_ready (dist_ready)
   );

   // nearest palette color, lower index wins a tie
   epp_argmin u_argmin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dist_valid),
      .in_data   (dist_data),
      .in_ready  (dist_ready),
      .out_valid (pick_valid),
      .out_data  (pick_data),
      .out_ready (pick_ready)
   );

   // bit-plane shifting, group closing and result register
   epp_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pick_valid),
      .in_data   (pick_data),
      .in_ready  (pick_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   assign req_stall = !req_ready;

endmodule
